FILE: design/scgp_pkg.sv
// Shared types, mode codes and Golay nibble tables for the SC-PHY preamble generator.
// No dependencies; used by scgp_chip_rom and the core.
package scgp_pkg;

  // Preamble mode register codes
  localparam logic [1:0] MODE_CMS     = 2'd0;
  localparam logic [1:0] MODE_MR      = 2'd1;
  localparam logic [1:0] MODE_HR      = 2'd2;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  // Segment codes
  localparam logic [1:0] SEG_SYNC = 2'd0;
  localparam logic [1:0] SEG_SFD  = 2'd1;
  localparam logic [1:0] SEG_CES  = 2'd2;

  // Word counts in units of 128 chips
  localparam int unsigned WordLenLog = 7;
  localparam logic [6:0] CmsSyncEnd = 7'd48;
  localparam logic [6:0] CmsSfdEnd  = 7'd55;
  localparam logic [6:0] CmsLenW    = 7'd65;
  localparam logic [6:0] HrSyncEnd  = 7'd14;
  localparam logic [6:0] HrSfdEnd   = 7'd18;
  localparam logic [6:0] HrLenW     = 7'd27;

  // SFD complement flags, bit i applies to SFD word i
  localparam logic [7:0] SfdFlipCms = 8'h72;
  localparam logic [7:0] SfdFlipMr  = 8'h0A;
  localparam logic [7:0] SfdFlipHr  = 8'h0C;

  localparam logic [3:0] GolayA [32] = '{
    4'h0, 4'h5, 4'h3, 4'h6, 4'h6, 4'h3, 4'h5, 4'h0,
    4'h0, 4'h5, 4'hC, 4'h9, 4'h6, 4'h3, 4'hA, 4'hF,
    4'hF, 4'hA, 4'hC, 4'h9, 4'h9, 4'hC, 4'hA, 4'hF,
    4'h0, 4'h5, 4'hC, 4'h9, 4'h6, 4'h3, 4'hA, 4'hF};
  localparam logic [3:0] GolayB [32] = '{
    4'h0, 4'hA, 4'h3, 4'h9, 4'h6, 4'hC, 4'h5, 4'hF,
    4'h0, 4'hA, 4'hC, 4'h6, 4'h6, 4'hC, 4'hA, 4'h0,
    4'hF, 4'h5, 4'hC, 4'h6, 4'h9, 4'h3, 4'hA, 4'h0,
    4'h0, 4'hA, 4'hC, 4'h6, 4'h6, 4'hC, 4'hA, 4'h0};

  // One chip of a Golay 128 word, nibbles expanded MSB first
  function automatic logic golay_bit(input logic use_b, input logic [6:0] idx);
    logic [3:0] nib;
    nib = use_b ? GolayB[idx[6:2]] : GolayA[idx[6:2]];
    return nib[~idx[1:0]];
  endfunction

  // Chip lookup result
  typedef struct packed {
    logic       chip;
    logic [1:0] segment;
    logic       in_range;
    logic       last;
  } chip_info_t;

endpackage

FILE: design/sc_phy_golay_preamble_generator_core.sv
// Top level of the SC-PHY Golay preamble generator: sequencing state and result register.
// Depends on scgp_pkg and scgp_chip_rom.
//
// Each accepted request yields one result: a preamble chip with its segment, active
// and last flags, or an idle result when the generator is not running or the mode is
// invalid. A request with restart set emits the first chip of the preamble in its own
// result. One request is accepted every clock unless the output stalls; the rate is set
// by the single result register, which takes a new request whenever it is empty or
// being drained in the same cycle. Mode 0 runs 8320 chips, modes 1 and 2 run 3456.
module sc_phy_golay_preamble_generator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       restart_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       chip_o,
  output logic [1:0] segment_o,
  output logic       active_o,
  output logic       last_o,
  output logic       mode_error_o
);

  logic [1:0]  mode_q;
  logic [13:0] pos_q, pos_d;
  logic        running_q, running_d;
  logic        out_valid_q;
  logic        chip_q, active_q, last_q, mode_error_q;
  logic [1:0]  segment_q;

  logic        accept;
  logic        run;
  logic [13:0] pos_cur;
  logic        mode_ok;
  logic        fire;
  scgp_pkg::chip_info_t info;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Resolve restart before lookup
  assign run     = restart_i || running_q;
  assign pos_cur = restart_i ? '0 : pos_q;
  assign mode_ok = (mode_q != scgp_pkg::MODE_INVALID);

  scgp_chip_rom u_rom (
    .mode_i (mode_q),
    .pos_i  (pos_cur),
    .info_o (info)
  );

  assign fire      = run && mode_ok && info.in_range;
  assign pos_d     = fire ? pos_cur + 14'd1 : pos_cur;
  assign running_d = fire && !info.last;

  // Hold mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= scgp_pkg::MODE_CMS;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Advance sequencing state on each request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q     <= pos_d;
        running_q <= running_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      chip_q       <= fire && info.chip;
      segment_q    <= fire ? info.segment : scgp_pkg::SEG_SYNC;
      active_q     <= fire;
      last_q       <= fire && info.last;
      mode_error_q <= !mode_ok;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign chip_o       = chip_q;
  assign segment_o    = segment_q;
  assign active_o     = active_q;
  assign last_o       = last_q;
  assign mode_error_o = mode_error_q;

  // Checks
  a_last_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> active_q)
    else $error("last flagged on an inactive chip");

  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && mode_error_q |-> !active_q)
    else $error("chip produced with invalid mode");

  a_restart_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && restart_i && mode_ok && !cfg_we_i |=>
      out_valid_q && active_q && (segment_q == scgp_pkg::SEG_SYNC) && !last_q)
    else $error("restart did not emit first sync chip");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && active_q |-> (segment_q <= scgp_pkg::SEG_CES))
    else $error("segment code out of range");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && fire && info.last |=> !running_q)
    else $error("generator still running after final chip");

endmodule

FILE: design/scgp_chip_rom.sv
// Position-to-chip decode for the SC-PHY preamble: segment, chip bit, range and last flag.
// Depends on scgp_pkg.
module scgp_chip_rom (
  input  logic [1:0]               mode_i,
  input  logic [13:0]              pos_i,
  output scgp_pkg::chip_info_t     info_o
);

  logic       cms;
  logic [6:0] wi;
  logic [6:0] offs;
  logic [6:0] sync_end;
  logic [6:0] sfd_end;
  logic [6:0] len_w;
  logic [7:0] flips;
  logic [6:0] sfd_word;
  logic [6:0] ces_word;

  assign cms  = (mode_i == scgp_pkg::MODE_CMS);
  assign wi   = pos_i[13:scgp_pkg::WordLenLog];
  assign offs = pos_i[scgp_pkg::WordLenLog-1:0];

  // Select per-mode layout
  always_comb begin
    sync_end = cms ? scgp_pkg::CmsSyncEnd : scgp_pkg::HrSyncEnd;
    sfd_end  = cms ? scgp_pkg::CmsSfdEnd  : scgp_pkg::HrSfdEnd;
    len_w    = cms ? scgp_pkg::CmsLenW    : scgp_pkg::HrLenW;
    case (mode_i)
      scgp_pkg::MODE_CMS: flips = scgp_pkg::SfdFlipCms;
      scgp_pkg::MODE_MR:  flips = scgp_pkg::SfdFlipMr;
      scgp_pkg::MODE_HR:  flips = scgp_pkg::SfdFlipHr;
      default:            flips = '0;
    endcase
  end

  assign sfd_word = wi - sync_end;
  // Word index inside the 256 blocks of the CES, past the leading a128 in common mode
  assign ces_word = wi - sfd_end - {6'd0, cms};

  // Decode segment and chip bit
  always_comb begin
    info_o.in_range = (wi < len_w);
    info_o.last     = info_o.in_range && (wi == len_w - 7'd1) && (&offs);
    if (wi < sync_end) begin
      info_o.segment = scgp_pkg::SEG_SYNC;
      info_o.chip    = scgp_pkg::golay_bit(cms, offs);
    end else if (wi < sfd_end) begin
      info_o.segment = scgp_pkg::SEG_SFD;
      info_o.chip    = scgp_pkg::golay_bit(cms, offs) ^ flips[sfd_word[2:0]];
    end else begin
      info_o.segment = scgp_pkg::SEG_CES;
      if (cms && (wi == sfd_end)) begin
        // leading a128 of the common-mode CES
        info_o.chip = scgp_pkg::golay_bit(1'b0, offs);
      end else if (wi == len_w - 7'd1) begin
        // trailing b128
        info_o.chip = scgp_pkg::golay_bit(1'b1, offs);
      end else begin
        // 256 blocks alternate a/b; second half complemented
        info_o.chip = scgp_pkg::golay_bit(ces_word[1], offs) ^ ces_word[0];
      end
    end
  end

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for sc_phy_golay_preamble_generator_core: directed table, then
// runs in every mode with mode switches and random restarts, checked against a chip predictor.
// Depends on scgp_pkg (mode and segment codes) and the core RTL.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic       chip;
    logic [1:0] segment;
    logic       active;
    logic       last;
    logic       mode_error;
  } preamble_chip_t;

  typedef struct packed {
    logic [1:0]     mode;
    logic           restart;
    logic           typed;
    preamble_chip_t want;
  } stim_row_t;

  localparam int unsigned WordChips    = 128;
  localparam int unsigned CmsChips     = 8320;
  localparam int unsigned HrChips      = 3456;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned HoldCycles   = 64;
  localparam int unsigned HoldAtResult = 300;
  localparam int unsigned CycleLimit   = 500000;

  // Golay 128 words as bit strings, chip 0 in the top bit
  localparam logic [127:0] GolayABits = 128'h05366350_05C963AF_FAC99CAF_05C963AF;
  localparam logic [127:0] GolayBBits = 128'h0A396C5F_0AC66CA0_F5C693A0_0AC66CA0;

  localparam preamble_chip_t IdleChip  = '0;
  localparam preamble_chip_t FirstChip = '{chip: 1'b0, segment: scgp_pkg::SEG_SYNC,
                                           active: 1'b1, last: 1'b0, mode_error: 1'b0};
  localparam preamble_chip_t ErrorChip = '{chip: 1'b0, segment: scgp_pkg::SEG_SYNC,
                                           active: 1'b0, last: 1'b0, mode_error: 1'b1};

  // Directed requests: idle after reset, start, invalid mode, mode switches while running
  localparam stim_row_t DirectedRows [21] = '{
    '{scgp_pkg::MODE_CMS,     1'b0, 1'b1, IdleChip},
    '{scgp_pkg::MODE_CMS,     1'b1, 1'b1, FirstChip},
    '{scgp_pkg::MODE_CMS,     1'b0, 1'b0, IdleChip},
    '{scgp_pkg::MODE_CMS,     1'b0, 1'b0, IdleChip},
    '{scgp_pkg::MODE_CMS,     1'b0, 1'b0, IdleChip},
    '{scgp_pkg::MODE_CMS,     1'b0, 1'b0, IdleChip},
    '{scgp_pkg::MODE_CMS,     1'b0, 1'b0, IdleChip},
    '{scgp_pkg::MODE_CMS,     1'b0, 1'b0, IdleChip},
    '{scgp_pkg::MODE_CMS,     1'b0, 1'b0, IdleChip},
    '{scgp_pkg::MODE_INVALID, 1'b0, 1'b1, ErrorChip},
    '{scgp_pkg::MODE_INVALID, 1'b1, 1'b1, ErrorChip},
    '{scgp_pkg::MODE_CMS,     1'b0, 1'b1, IdleChip},
    '{scgp_pkg::MODE_MR,      1'b1, 1'b1, FirstChip},
    '{scgp_pkg::MODE_MR,      1'b0, 1'b0, IdleChip},
    '{scgp_pkg::MODE_HR,      1'b0, 1'b0, IdleChip},
    '{scgp_pkg::MODE_HR,      1'b1, 1'b1, FirstChip},
    '{scgp_pkg::MODE_HR,      1'b0, 1'b0, IdleChip},
    '{scgp_pkg::MODE_CMS,     1'b0, 1'b0, IdleChip},
    '{scgp_pkg::MODE_CMS,     1'b1, 1'b1, FirstChip},
    '{scgp_pkg::MODE_CMS,     1'b0, 1'b0, IdleChip},
    '{scgp_pkg::MODE_CMS,     1'b0, 1'b0, IdleChip}
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_wdata_i = scgp_pkg::MODE_CMS;
  logic       in_valid_i  = 1'b0;
  logic       restart_i   = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       chip_o;
  logic [1:0] segment_o;
  logic       active_o;
  logic       last_o;
  logic       mode_error_o;

  // Generator model state and the chips still owed by the block
  logic [1:0]     gen_mode    = scgp_pkg::MODE_CMS;
  int unsigned    gen_pos     = 0;
  logic           gen_running = 1'b0;
  preamble_chip_t pending_chips [$];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left    = 0;
  int unsigned cycle_count  = 0;
  bit          steady       = 1'b0;

  sc_phy_golay_preamble_generator_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .chip_o       (chip_o),
    .segment_o    (segment_o),
    .active_o     (active_o),
    .last_o       (last_o),
    .mode_error_o (mode_error_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic golay128(input logic use_b, input int unsigned k);
    int unsigned i;
    i = k % WordChips;
    return use_b ? GolayBBits[127 - i] : GolayABits[127 - i];
  endfunction

  // Look up the chip and segment at position p of the preamble in mode m
  function automatic void chip_lookup(input logic [1:0] m, input int unsigned p,
                                      output logic chip, output logic [1:0] seg);
    logic        cms;
    logic [7:0]  flips;
    int unsigned sync_end;
    int unsigned sfd_end;
    int unsigned o;
    int unsigned w;
    cms      = (m == scgp_pkg::MODE_CMS);
    sync_end = (cms ? 48 : 14) * WordChips;
    sfd_end  = sync_end + (cms ? 7 : 4) * WordChips;
    flips    = cms ? 8'h72 : ((m == scgp_pkg::MODE_MR) ? 8'h0A : 8'h0C);
    if (p < sync_end) begin
      seg  = scgp_pkg::SEG_SYNC;
      chip = golay128(cms, p);
    end else if (p < sfd_end) begin
      seg  = scgp_pkg::SEG_SFD;
      w    = (p - sync_end) / WordChips;
      chip = golay128(cms, p - sync_end) ^ flips[w];
    end else begin
      seg = scgp_pkg::SEG_CES;
      o   = p - sfd_end;
      if (cms && o < WordChips) begin
        chip = golay128(1'b0, o);
      end else begin
        if (cms) o = o - WordChips;
        // 256 blocks alternate a/b; the second half of each block is complemented
        if (o < 4 * 256) chip = golay128(o[8], o) ^ o[7];
        else chip = golay128(1'b1, o - 4 * 256);
      end
    end
  endfunction

  // Advance the generator by one request and return the chip it yields
  function automatic preamble_chip_t next_preamble_chip(input logic restart);
    preamble_chip_t res;
    logic           bad;
    int unsigned    plen;
    res            = '0;
    bad            = (gen_mode == scgp_pkg::MODE_INVALID);
    res.mode_error = bad;
    plen           = (gen_mode == scgp_pkg::MODE_CMS) ? CmsChips : HrChips;
    if (restart) begin
      gen_pos     = 0;
      gen_running = 1'b1;
    end
    if (gen_running && !bad && gen_pos < plen) begin
      chip_lookup(gen_mode, gen_pos, res.chip, res.segment);
      res.active = 1'b1;
      res.last   = (gen_pos + 1 == plen);
      gen_pos    = gen_pos + 1;
      if (res.last) gen_running = 1'b0;
    end else begin
      gen_running = 1'b0;
    end
    return res;
  endfunction

  // Offer one request, with random idle cycles first unless steady, and record what it must yield
  task automatic offer_request(input logic restart, input logic typed,
                               input preamble_chip_t want);
    preamble_chip_t predicted;
    while (!steady && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    predicted = next_preamble_chip(restart);
    pending_chips = {pending_chips, typed ? want : predicted};
  endtask

  // Hold requests until every chip is back, then let the block settle
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (pending_chips.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] m);
    drain_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gen_mode = m;
  endtask

  task automatic run_phase(input logic [1:0] m, input int unsigned count,
                           input logic first_restart, input int unsigned restart_permille);
    write_mode(m);
    for (int unsigned i = 0; i < count; i++) begin
      offer_request((i == 0 && first_restart) || ($urandom_range(999) < restart_permille),
                    1'b0, IdleChip);
    end
  endtask

  task automatic check_field(input string name, input logic [1:0] want,
                             input logic [1:0] got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Stimulus: directed table, then runs in every mode, mode switches and random restarts
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirectedRows[k]) begin
      if (DirectedRows[k].mode != gen_mode) write_mode(DirectedRows[k].mode);
      offer_request(DirectedRows[k].restart, DirectedRows[k].typed, DirectedRows[k].want);
    end
    run_phase(scgp_pkg::MODE_MR, 200, 1'b1, 0);
    run_phase(scgp_pkg::MODE_HR, 200, 1'b1, 0);
    steady = 1'b1;
    run_phase(scgp_pkg::MODE_CMS, 300, 1'b1, 0);
    steady = 1'b0;
    // Switch modes mid-run without a restart
    run_phase(scgp_pkg::MODE_CMS, 100, 1'b0, 0);
    run_phase(scgp_pkg::MODE_HR, 50, 1'b0, 0);
    run_phase(scgp_pkg::MODE_MR, 100, 1'b0, 0);
    run_phase(scgp_pkg::MODE_INVALID, 30, 1'b0, 100);
    repeat (7) run_phase(2'($urandom_range(3)), 50, 1'($urandom_range(1)), 5);
    drain_block();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Check each accepted result and drive the output stall
  always @(posedge clk_i) begin : result_check
    preamble_chip_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_chips.size() == 0) begin
        $error("unexpected result: chip %0d segment %0d active %0d", chip_o, segment_o,
               active_o);
        mismatches++;
      end else begin
        want = pending_chips.pop_front();
        check_field("chip", 2'(want.chip), 2'(chip_o));
        check_field("segment", want.segment, segment_o);
        check_field("active", 2'(want.active), 2'(active_o));
        check_field("last", 2'(want.last), 2'(last_o));
        check_field("mode_error", 2'(want.mode_error), 2'(mode_error_o));
      end
      results_seen++;
      if (results_seen == HoldAtResult) hold_left = HoldCycles;
    end
    // Hold off for a long stretch once, otherwise stall at random
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < 33);
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

endmodule
